// ===== hdl/trrs_pkg.sv =====
// ============================================================================
// trrs_pkg
// Types and constants shared by the two-level round-robin thread scheduler.
// ============================================================================
package trrs_pkg;

    localparam int ID_W            = 6;
    localparam int QW              = 8;
    localparam int CNT_W           = 7;
    localparam int MAX_THREADS_DEF = 64;
    localparam logic [QW-1:0] QUANTUM_RESET = 8'd4;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_CREATE = 3'd1,
        REQ_WAKEUP = 3'd2,
        REQ_SLEEP  = 3'd3,
        REQ_EXIT   = 3'd4,
        REQ_ELECT  = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_DEAD  = 2'd0,
        ST_WAIT  = 2'd1,
        ST_READY = 2'd2,
        ST_RUN   = 2'd3
    } t_status;

    typedef struct packed {
        logic    kernel;
        t_status status;
    } t_tent;

    typedef struct packed {
        logic [2:0]      req_type;
        logic [ID_W-1:0] thread_id;
        logic            is_kernel;
    } t_in;

    typedef struct packed {
        logic             elected_valid;
        logic [ID_W-1:0]  elected_id;
        logic             elected_kernel;
        logic             resched_request;
        logic [CNT_W-1:0] ready_count;
        logic [CNT_W-1:0] user_threads;
        logic [CNT_W-1:0] total_threads;
        logic             rejected;
    } t_out;

endpackage

// ===== hdl/trrs_ram.sv =====
// ============================================================================
// trrs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module trrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hdl/two_level_round_robin_thread_scheduler.sv =====
// ============================================================================
// two_level_round_robin_thread_scheduler
// Each accepted transaction is registered in the input register and its
// result in the result register. Transactions are taken one per cycle while
// the receiver does not stall, set by the single execute stage and the one
// write port of the thread-status RAM. Reset is synchronous: deques empty,
// all threads dead through per-thread valid bits.
// Kernel and user ready deques with a cached head entry each; kernel first.
// ============================================================================
module two_level_round_robin_thread_scheduler #(
    parameter int MAX_THREADS = trrs_pkg::MAX_THREADS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  trrs_pkg::t_in           i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output trrs_pkg::t_out          o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [trrs_pkg::QW-1:0] i_cfg_data
);

    import trrs_pkg::*;

    localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int FW = $clog2(MAX_THREADS + 1);
    localparam int SW = FW + 1;
    localparam int XW = AW + ID_W;
    localparam int RW = SW + CNT_W;
    localparam int TW = $bits(t_tent);
    localparam int DQ_K = 0;
    localparam int DQ_U = 1;
    localparam logic [AW-1:0] LAST = AW'(MAX_THREADS - 1);
    localparam logic [FW-1:0] FULL = FW'(MAX_THREADS);

    typedef struct packed {
        logic [AW-1:0]   head;
        logic [FW-1:0]   fill;
        logic [ID_W-1:0] hv;
    } t_dq;

    function automatic logic [AW-1:0] to_addr(input logic [ID_W-1:0] id);
        logic [XW-1:0] x;
        x = XW'(id);
        return x[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] a);
        return (a == '0) ? LAST : a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] h,
                                                input logic [FW-1:0] f);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(f);
        if (s >= SW'(MAX_THREADS)) begin
            s = s - SW'(MAX_THREADS);
        end
        return s[AW-1:0];
    endfunction

    // handshake
    logic s1_go, in_acc;

    // registers
    logic [QW-1:0]          r_quantum;
    logic                   r_s1_valid;
    t_in                    r_in;
    logic                   r_st_fhit;
    t_tent                  r_st_fdata;
    logic [MAX_THREADS-1:0] r_st_vld;
    t_dq                    r_dq [2];
    logic [1:0]             r_dq_fhit;
    logic [ID_W-1:0]        r_dq_fdata [2];
    logic [ID_W-1:0]        r_run_id;
    logic                   r_run_valid;
    logic                   r_cur_run;
    logic                   r_cur_kernel;
    logic [QW-1:0]          r_ql;
    logic                   r_resched;
    logic [CNT_W-1:0]       r_user_cnt;
    logic [CNT_W-1:0]       r_total_cnt;
    logic                   r_out_valid;
    t_out                   r_out;

    // next state
    t_dq                    n_dq [2];
    logic [1:0]             n_dq_fhit;
    logic [ID_W-1:0]        n_run_id;
    logic                   n_run_valid;
    logic                   n_cur_run;
    logic                   n_cur_kernel;
    logic [QW-1:0]          n_ql;
    logic                   n_resched;
    logic [CNT_W-1:0]       n_user_cnt;
    logic [CNT_W-1:0]       n_total_cnt;
    logic                   n_st_fhit;
    t_out                   n_out;

    // execute stage
    t_req                   req;
    logic                   tid_ok;
    logic [AW-1:0]          t_addr;
    logic [AW-1:0]          r_addr;
    t_tent                  t_ent;
    t_status                t_stat;
    logic [TW-1:0]          st_rdata;
    logic [AW-1:0]          st_raddr;
    logic                   st_we;
    logic [AW-1:0]          st_waddr;
    t_tent                  st_wdata;
    logic [1:0]             push_h, push_t, pop_en;
    logic [ID_W-1:0]        push_val;
    logic                   elect_pop;
    logic [QW-1:0]          ql_dec;
    logic [1:0]             dq_we;
    logic [AW-1:0]          dq_waddr [2];
    logic [AW-1:0]          dq_raddr [2];
    logic [ID_W-1:0]        dq_rdata [2];
    logic [ID_W-1:0]        dq_next  [2];
    logic [RW-1:0]          rdy_wide;

    assign s1_go       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_go;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // thread status and kind, read when a transaction is accepted
    assign st_raddr  = to_addr(i_in_data.thread_id);
    assign n_st_fhit = s1_go && st_we && (st_waddr == st_raddr);

    trrs_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_THREADS)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go && st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (in_acc),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // ready deques; each RAM keeps the entry after the head on its read port
    for (genvar g = 0; g < 2; g++) begin : g_dq
        trrs_ram #(
            .WIDTH (ID_W),
            .DEPTH (MAX_THREADS)
        ) u_dq_ram (
            .i_clk   (i_clk),
            .i_we    (s1_go && dq_we[g]),
            .i_waddr (dq_waddr[g]),
            .i_wdata (push_val),
            .i_re    (1'b1),
            .i_raddr (dq_raddr[g]),
            .o_rdata (dq_rdata[g])
        );
        assign dq_next[g] = r_dq_fhit[g] ? r_dq_fdata[g] : dq_rdata[g];
    end

    assign req    = t_req'(r_in.req_type);
    assign tid_ok = int'(r_in.thread_id) < MAX_THREADS;
    assign t_addr = to_addr(r_in.thread_id);
    assign r_addr = to_addr(r_run_id);
    assign t_ent  = r_st_fhit ? r_st_fdata :
                    (r_st_vld[t_addr] ? t_tent'(st_rdata) :
                                        t_tent'{kernel: 1'b0, status: ST_DEAD});
    assign t_stat = (r_cur_run && (r_in.thread_id == r_run_id)) ? ST_RUN
                                                                : t_ent.status;

    always_comb begin
        st_we        = 1'b0;
        st_waddr     = t_addr;
        st_wdata     = '{kernel: r_in.is_kernel, status: ST_READY};
        push_h       = '0;
        push_t       = '0;
        pop_en       = '0;
        push_val     = r_in.thread_id;
        elect_pop    = 1'b0;
        ql_dec       = '0;
        n_run_id     = r_run_id;
        n_run_valid  = r_run_valid;
        n_cur_run    = r_cur_run;
        n_cur_kernel = r_cur_kernel;
        n_ql         = r_ql;
        n_resched    = r_resched;
        n_user_cnt   = r_user_cnt;
        n_total_cnt  = r_total_cnt;
        n_out        = '0;

        unique case (req)
            REQ_TICK: begin
                if (r_run_valid) begin
                    ql_dec = (r_ql != '0) ? r_ql - 1'b1 : '0;
                    n_ql   = ql_dec;
                    if (ql_dec == '0) begin
                        n_resched = 1'b1;
                    end
                end
            end
            REQ_CREATE: begin
                if (!tid_ok || t_stat != ST_DEAD) begin
                    n_out.rejected = 1'b1;
                end else begin
                    st_we       = 1'b1;
                    n_total_cnt = r_total_cnt + 1'b1;
                    if (r_in.is_kernel) begin
                        push_h[DQ_K] = 1'b1;
                    end else begin
                        n_user_cnt   = r_user_cnt + 1'b1;
                        push_t[DQ_U] = 1'b1;
                    end
                end
            end
            REQ_WAKEUP: begin
                if (!tid_ok || t_stat == ST_DEAD || t_stat == ST_RUN) begin
                    n_out.rejected = 1'b1;
                end else if (t_stat == ST_WAIT) begin
                    st_we    = 1'b1;
                    st_wdata = '{kernel: t_ent.kernel, status: ST_READY};
                    if (t_ent.kernel) begin
                        push_h[DQ_K] = 1'b1;
                        n_resched    = 1'b1;
                    end else begin
                        push_h[DQ_U] = 1'b1;
                    end
                end
            end
            REQ_SLEEP, REQ_EXIT: begin
                if (!r_run_valid || !r_cur_run) begin
                    n_out.rejected = 1'b1;
                end else begin
                    st_we     = 1'b1;
                    st_waddr  = r_addr;
                    st_wdata  = '{kernel: r_cur_kernel,
                                  status: (req == REQ_SLEEP) ? ST_WAIT : ST_DEAD};
                    n_cur_run = 1'b0;
                    if (req == REQ_EXIT) begin
                        n_total_cnt = r_total_cnt - 1'b1;
                        if (!r_cur_kernel) begin
                            n_user_cnt = r_user_cnt - 1'b1;
                        end
                    end
                end
            end
            REQ_ELECT: begin
                n_resched = 1'b0;
                elect_pop = 1'b1;
                push_val  = r_run_id;
                if (r_run_valid && r_cur_run) begin
                    if (r_cur_kernel) begin
                        push_t[DQ_K] = 1'b1;
                    end else begin
                        push_t[DQ_U] = 1'b1;
                    end
                end
            end
            default: begin
                n_out.rejected = 1'b1;
            end
        endcase

        // pushes
        for (int d = 0; d < 2; d++) begin
            n_dq[d]     = r_dq[d];
            dq_we[d]    = 1'b0;
            dq_waddr[d] = r_dq[d].head;
            if (push_h[d] && r_dq[d].fill != FULL) begin
                n_dq[d].head = dec_wrap(r_dq[d].head);
                n_dq[d].hv   = push_val;
                n_dq[d].fill = r_dq[d].fill + 1'b1;
                dq_waddr[d]  = dec_wrap(r_dq[d].head);
                dq_we[d]     = 1'b1;
            end
            if (push_t[d] && r_dq[d].fill != FULL) begin
                if (r_dq[d].fill == '0) begin
                    n_dq[d].hv = push_val;
                end
                n_dq[d].fill = r_dq[d].fill + 1'b1;
                dq_waddr[d]  = add_wrap(r_dq[d].head, r_dq[d].fill);
                dq_we[d]     = 1'b1;
            end
        end

        // elect pops the kernel deque first
        pop_en[DQ_K] = elect_pop && (n_dq[DQ_K].fill != '0);
        pop_en[DQ_U] = elect_pop && (n_dq[DQ_K].fill == '0) && (n_dq[DQ_U].fill != '0);
        for (int d = 0; d < 2; d++) begin
            if (pop_en[d]) begin
                n_out.elected_valid  = 1'b1;
                n_out.elected_id     = n_dq[d].hv;
                n_out.elected_kernel = (d == DQ_K);
                n_dq[d].head = inc_wrap(n_dq[d].head);
                n_dq[d].fill = n_dq[d].fill - 1'b1;
                n_dq[d].hv   = (push_t[d] && r_dq[d].fill == FW'(1)) ? push_val
                                                                      : dq_next[d];
            end
        end
        if (elect_pop) begin
            if (pop_en != '0) begin
                n_run_id     = n_out.elected_id;
                n_run_valid  = 1'b1;
                n_cur_run    = 1'b1;
                n_cur_kernel = n_out.elected_kernel;
                n_ql         = r_quantum;
            end else begin
                n_run_valid = 1'b0;
                n_cur_run   = 1'b0;
                n_ql        = '0;
            end
        end

        for (int d = 0; d < 2; d++) begin
            dq_raddr[d]  = inc_wrap(s1_go ? n_dq[d].head : r_dq[d].head);
            n_dq_fhit[d] = s1_go && dq_we[d] && (dq_waddr[d] == dq_raddr[d]);
        end

        rdy_wide              = RW'(n_dq[DQ_K].fill) + RW'(n_dq[DQ_U].fill);
        n_out.resched_request = n_resched;
        n_out.ready_count     = rdy_wide[CNT_W-1:0];
        n_out.user_threads    = n_user_cnt;
        n_out.total_threads   = n_total_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum    <= QUANTUM_RESET;
            r_s1_valid   <= 1'b0;
            r_st_vld     <= '0;
            r_dq[DQ_K]   <= '0;
            r_dq[DQ_U]   <= '0;
            r_run_id     <= '0;
            r_run_valid  <= 1'b0;
            r_cur_run    <= 1'b0;
            r_cur_kernel <= 1'b0;
            r_ql         <= '0;
            r_resched    <= 1'b0;
            r_user_cnt   <= '0;
            r_total_cnt  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_quantum <= i_cfg_data;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                if (st_we) begin
                    r_st_vld[st_waddr] <= 1'b1;
                end
                r_dq[DQ_K]   <= n_dq[DQ_K];
                r_dq[DQ_U]   <= n_dq[DQ_U];
                r_run_id     <= n_run_id;
                r_run_valid  <= n_run_valid;
                r_cur_run    <= n_cur_run;
                r_cur_kernel <= n_cur_kernel;
                r_ql         <= n_ql;
                r_resched    <= n_resched;
                r_user_cnt   <= n_user_cnt;
                r_total_cnt  <= n_total_cnt;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in       <= i_in_data;
            r_st_fhit  <= n_st_fhit;
            r_st_fdata <= st_wdata;
        end
        r_dq_fhit     <= n_dq_fhit;
        r_dq_fdata[0] <= push_val;
        r_dq_fdata[1] <= push_val;
        if (s1_go) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/trrs_checker.sv =====
// ============================================================================
// trrs_checker
// Port-level checks for the thread scheduler, bound to the top level.
// ============================================================================
module trrs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input trrs_pkg::t_out o_out_data
);

    import trrs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result transaction changed while stalled");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.ready_count <= o_out_data.total_threads) &&
                        (o_out_data.user_threads <= o_out_data.total_threads))
        else $error("thread counts inconsistent");

    a_elect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.elected_valid |->
            !o_out_data.rejected && !o_out_data.resched_request)
        else $error("elect result flagged rejected or reschedule");

    a_no_elect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.elected_valid |->
            (o_out_data.elected_id == '0) && !o_out_data.elected_kernel)
        else $error("elected fields set without an election");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind two_level_round_robin_thread_scheduler trrs_checker u_trrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== sim/two_level_round_robin_thread_scheduler_tb.sv =====
// ============================================================================
// two_level_round_robin_thread_scheduler_tb
// Self-checking bench for the two-level thread scheduler. A behavioral copy
// of the scheduler state predicts the result of every accepted request, and a
// checker compares each result field by field in order. Directed requests
// hit the idle, reject and quantum corner cases. Random phases then run at
// several quantum settings with thread-aware request mixes, random sender
// gaps and receiver stalls.
// ============================================================================
module two_level_round_robin_thread_scheduler_tb;
    import trrs_pkg::*;

    localparam int NTHR      = 64;
    localparam int CYC_LIMIT = 400000;
    localparam int PHASE_LEN = 200;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_ready;
    t_in             i_in_data   = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    t_out            o_out_data;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [QW-1:0]   i_cfg_data  = '0;

    two_level_round_robin_thread_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // scheduler shadow state; deque index 1 is kernel, 0 is user
    logic [ID_W-1:0]  dq_slot [2][NTHR];
    logic [ID_W-1:0]  dq_head [2];
    logic [CNT_W-1:0] dq_fill [2];
    t_status          thr_state [NTHR];
    logic             thr_kern [NTHR];
    logic [ID_W-1:0]  cur_id;
    logic             cur_valid;
    logic [QW-1:0]    qleft;
    logic             resched;
    logic [CNT_W-1:0] n_user;
    logic [CNT_W-1:0] n_total;
    logic [QW-1:0]    quantum_cfg;

    t_out pending_results [$];
    bit   idle_on = 1'b1;
    int   err_cnt = 0;
    int   n_items = 0;
    int   n_won   = 0;
    int   n_rej   = 0;
    int   n_cfg   = 0;
    int   cycles  = 0;

    function automatic void reset_model();
        for (int i = 0; i < NTHR; i++) begin
            thr_state[i] = ST_DEAD;
            thr_kern[i]  = 1'b0;
        end
        for (int k = 0; k < 2; k++) begin
            dq_head[k] = '0;
            dq_fill[k] = '0;
        end
        cur_id      = '0;
        cur_valid   = 1'b0;
        qleft       = '0;
        resched     = 1'b0;
        n_user      = '0;
        n_total     = '0;
        quantum_cfg = QUANTUM_RESET;
    endfunction

    function automatic void dq_push(logic k, logic at_head, logic [ID_W-1:0] id);
        if (dq_fill[k] >= NTHR)
            return;
        if (at_head) begin
            dq_head[k]             = dq_head[k] - 1'b1;
            dq_slot[k][dq_head[k]] = id;
        end else begin
            dq_slot[k][ID_W'(dq_head[k] + dq_fill[k])] = id;
        end
        dq_fill[k] = dq_fill[k] + 1'b1;
    endfunction

    function automatic logic [ID_W-1:0] dq_pop(logic k);
        logic [ID_W-1:0] id;
        id         = dq_slot[k][dq_head[k]];
        dq_head[k] = dq_head[k] + 1'b1;
        dq_fill[k] = dq_fill[k] - 1'b1;
        return id;
    endfunction

    function automatic t_out schedule_request(t_in item);
        t_out            r;
        logic [ID_W-1:0] t;
        logic [ID_W-1:0] cur;
        r   = '0;
        t   = item.thread_id;
        cur = cur_id;
        case (item.req_type)
            REQ_TICK: begin
                if (cur_valid) begin
                    if (qleft != 0)
                        qleft = qleft - 1'b1;
                    if (qleft == 0)
                        resched = 1'b1;
                end
            end
            REQ_CREATE: begin
                if (thr_state[t] != ST_DEAD) begin
                    r.rejected = 1'b1;
                end else begin
                    thr_state[t] = ST_READY;
                    thr_kern[t]  = item.is_kernel;
                    n_total      = n_total + 1'b1;
                    if (item.is_kernel) begin
                        dq_push(1'b1, 1'b1, t);
                    end else begin
                        n_user = n_user + 1'b1;
                        dq_push(1'b0, 1'b0, t);
                    end
                end
            end
            REQ_WAKEUP: begin
                if (thr_state[t] == ST_DEAD || thr_state[t] == ST_RUN) begin
                    r.rejected = 1'b1;
                end else if (thr_state[t] == ST_WAIT) begin
                    thr_state[t] = ST_READY;
                    dq_push(thr_kern[t], 1'b1, t);
                    if (thr_kern[t])
                        resched = 1'b1;
                end
            end
            REQ_SLEEP, REQ_EXIT: begin
                if (!cur_valid || thr_state[cur] != ST_RUN) begin
                    r.rejected = 1'b1;
                end else if (item.req_type == REQ_SLEEP) begin
                    thr_state[cur] = ST_WAIT;
                end else begin
                    thr_state[cur] = ST_DEAD;
                    n_total        = n_total - 1'b1;
                    if (!thr_kern[cur])
                        n_user = n_user - 1'b1;
                end
            end
            REQ_ELECT: begin
                if (cur_valid && thr_state[cur] == ST_RUN) begin
                    thr_state[cur] = ST_READY;
                    dq_push(thr_kern[cur], 1'b0, cur);
                end
                resched = 1'b0;
                if (dq_fill[1] != 0 || dq_fill[0] != 0) begin
                    r.elected_id             = dq_pop(dq_fill[1] != 0);
                    r.elected_valid          = 1'b1;
                    r.elected_kernel         = thr_kern[r.elected_id];
                    thr_state[r.elected_id]  = ST_RUN;
                    cur_id                   = r.elected_id;
                    cur_valid                = 1'b1;
                    qleft                    = quantum_cfg;
                end else begin
                    cur_valid = 1'b0;
                    qleft     = '0;
                end
            end
            default: begin
                r.rejected = 1'b1;
            end
        endcase
        r.resched_request = resched;
        r.ready_count     = dq_fill[0] + dq_fill[1];
        r.user_threads    = n_user;
        r.total_threads   = n_total;
        n_items++;
        n_won += r.elected_valid;
        n_rej += r.rejected;
        return r;
    endfunction

    task automatic send_req(input logic [2:0] rt, input logic [ID_W-1:0] tid,
                            input logic kern);
        t_in item;
        int  gap;
        item.req_type  = rt;
        item.thread_id = tid;
        item.is_kernel = kern;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(schedule_request(item));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [QW-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        quantum_cfg = v;
        n_cfg++;
    endtask

    function automatic int pick_thread(t_status st);
        int start;
        start = $urandom_range(0, NTHR - 1);
        for (int i = 0; i < NTHR; i++) begin
            if (thr_state[(start + i) % NTHR] == st)
                return (start + i) % NTHR;
        end
        return -1;
    endfunction

    task automatic send_random_req();
        int sel;
        int id;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            send_req(3'($urandom_range(0, 7)), ID_W'($urandom_range(0, NTHR - 1)),
                     1'($urandom_range(0, 1)));
        end else if (sel < 35) begin
            id = pick_thread(ST_DEAD);
            if (id < 0)
                id = $urandom_range(0, NTHR - 1);
            send_req(REQ_CREATE, ID_W'(id), $urandom_range(0, 2) == 0);
        end else if (sel < 45) begin
            id = pick_thread(ST_WAIT);
            if (id < 0)
                id = $urandom_range(0, NTHR - 1);
            send_req(REQ_WAKEUP, ID_W'(id), 1'($urandom_range(0, 1)));
        end else if (sel < 55) begin
            send_req(REQ_SLEEP, ID_W'($urandom_range(0, NTHR - 1)), 1'($urandom_range(0, 1)));
        end else if (sel < 63) begin
            send_req(REQ_EXIT, ID_W'($urandom_range(0, NTHR - 1)), 1'($urandom_range(0, 1)));
        end else if (sel < 78) begin
            send_req(REQ_ELECT, ID_W'($urandom_range(0, NTHR - 1)), 1'($urandom_range(0, 1)));
        end else begin
            send_req(REQ_TICK, ID_W'($urandom_range(0, NTHR - 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // requests against an empty scheduler at reset quantum
    task automatic test_idle_requests();
        send_req(REQ_ELECT, 6'd0, 1'b0);
        send_req(REQ_TICK, 6'd0, 1'b0);
        send_req(REQ_SLEEP, 6'd0, 1'b0);
        send_req(REQ_EXIT, 6'd0, 1'b0);
        send_req(REQ_WAKEUP, 6'd63, 1'b1);
        send_req(3'd6, 6'd0, 1'b0);
        send_req(3'd7, 6'd63, 1'b1);
    endtask

    task automatic test_thread_lifecycle();
        send_req(REQ_CREATE, 6'd0, 1'b0);
        send_req(REQ_CREATE, 6'd63, 1'b1);
        send_req(REQ_CREATE, 6'd0, 1'b1);
        send_req(REQ_CREATE, 6'd1, 1'b1);
        send_req(REQ_ELECT, 6'd0, 1'b0);
        send_req(REQ_WAKEUP, 6'd1, 1'b0);
        send_req(REQ_WAKEUP, 6'd0, 1'b0);
        repeat (5) send_req(REQ_TICK, 6'd0, 1'b0);
        send_req(REQ_SLEEP, 6'd0, 1'b0);
        send_req(REQ_SLEEP, 6'd0, 1'b0);
        send_req(REQ_ELECT, 6'd0, 1'b0);
        send_req(REQ_WAKEUP, 6'd1, 1'b0);
        send_req(REQ_EXIT, 6'd0, 1'b0);
        send_req(REQ_ELECT, 6'd0, 1'b0);
    endtask

    task automatic test_zero_quantum();
        write_quantum(8'd0);
        send_req(REQ_ELECT, 6'd0, 1'b0);
        send_req(REQ_TICK, 6'd0, 1'b0);
    endtask

    task automatic test_random_mix();
        logic [QW-1:0] q_set [7];
        int            pause_at;
        q_set = '{8'd1, 8'd255, 8'd2, 8'd7, 8'd1, 8'd3, 8'd128};
        q_set[4] = QW'($urandom_range(1, 255));
        for (int p = 0; p < 7; p++) begin
            write_quantum(q_set[p]);
            pause_at = $urandom_range(20, PHASE_LEN - 20);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (i % 40 == 0)
                    idle_on = $urandom_range(0, 3) != 0;
                if (i == pause_at)
                    wait_drained();
                send_random_req();
            end
        end
    endtask

    // receiver: random stall before each result
    initial begin : result_sink
        int n;
        @(posedge i_rst_n);
        forever begin
            n = idle_on ? $urandom_range(0, 12) : 0;
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no pending request");
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("elected_valid", want.elected_valid, o_out_data.elected_valid);
                check_field("elected_id", want.elected_id, o_out_data.elected_id);
                check_field("elected_kernel", want.elected_kernel, o_out_data.elected_kernel);
                check_field("resched_request", want.resched_request,
                            o_out_data.resched_request);
                check_field("ready_count", want.ready_count, o_out_data.ready_count);
                check_field("user_threads", want.user_threads, o_out_data.user_threads);
                check_field("total_threads", want.total_threads, o_out_data.total_threads);
                check_field("rejected", want.rejected, o_out_data.rejected);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYC_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_requests();
        test_thread_lifecycle();
        test_zero_quantum();
        test_random_mix();
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("ran %0d requests over %0d quantum settings", n_items, n_cfg);
        $display("%0d elects picked a thread, %0d requests were rejected", n_won, n_rej);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
